// ===== hdl/salp_pkg.sv =====
// ----------------------------------------------------------------------------
// salp_pkg: shared definitions for the array literal parser
// Byte codes of the literal syntax, result kinds and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package salp_pkg;

	// Bytes with a meaning in the literal syntax.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_OPEN  = 8'h7B;
	localparam logic [7:0] CH_CLOSE = 8'h7D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;

	// Kind of one result item.
	typedef enum logic [1:0] {
		K_DATA   = 2'd0,
		K_END    = 2'd1,
		K_ACCEPT = 2'd2,
		K_REJECT = 2'd3
	} kind_t;

	// Decision for one byte: whether a result is produced, and its contents.
	typedef struct packed {
		logic        hit;
		kind_t       kind;
		logic [7:0]  ch;
	} res_t;

endpackage

`default_nettype wire

// ===== hdl/sql_array_literal_parser.sv =====
// A request is registered in stage 1, and its result, if any, in the output register (stage 2).
// Throughput: one byte per cycle unless a byte waits for the output register; the phase register is the only loop.
// A byte that gives no result passes on while a result waits to be taken; a byte
// that gives a result waits until the output register is free.
// Reset (arst_n low, asynchronous) empties both stages and returns the parser
// to the start phase, expecting an opening brace or the terminator.
// ----------------------------------------------------------------------------
// sql_array_literal_parser: streaming parser for text array literals
// Takes one byte per request, strips quoting and escapes, and emits element
// bytes, element-end marks and an accept or reject verdict per string.
// ----------------------------------------------------------------------------
`default_nettype none

module sql_array_literal_parser (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] char_in
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] char_out
	output logic [1:0]      m_tuser    // [1:0] kind
);

	typedef enum logic [3:0] {
		PH_START    = 4'd0,
		PH_OPEN     = 4'd1,
		PH_ELEM     = 4'd2,
		PH_UNQ      = 4'd3,
		PH_QUOTE    = 4'd4,
		PH_ESC      = 4'd5,
		PH_AFTERQ   = 4'd6,
		PH_CLOSED   = 4'd7,
		PH_REJECTED = 4'd8
	} phase_t;

	logic              valid_s1;
	logic [7:0]        char_s1;
	logic              valid_s2;
	salp_pkg::kind_t   kind_s2;
	logic [7:0]        char_s2;
	phase_t            phase_q;
	phase_t            phase_nx;
	salp_pkg::res_t    res;
	logic              out_free;
	logic              advance;
	logic              out_load;
	logic              is_nul;

	// Handshake: stage 1 moves on when the output register can take its result, or when its byte gives no result.
	assign out_free = !valid_s2 || m_tready;
	assign advance  = valid_s1 && (out_free || !res.hit);
	assign out_load = advance && res.hit;
	assign s_tready = !valid_s1 || advance;
	assign is_nul   = (char_s1 == salp_pkg::CH_NUL);

	// Per-byte decision from the current phase.
	always_comb begin
		phase_nx = phase_q;
		res      = '{hit: 1'b0, kind: salp_pkg::K_DATA, ch: 8'h00};
		case (phase_q)
			PH_OPEN, PH_ELEM: begin
				if (phase_q == PH_OPEN && char_s1 == salp_pkg::CH_CLOSE) begin
					phase_nx = PH_CLOSED;
				end else if (char_s1 == salp_pkg::CH_QUOTE) begin
					phase_nx = PH_QUOTE;
				end else if (is_nul || char_s1 == salp_pkg::CH_OPEN) begin
					phase_nx = is_nul ? PH_START : PH_REJECTED;
					res      = '{hit: 1'b1, kind: salp_pkg::K_REJECT, ch: 8'h00};
				end else if (char_s1 == salp_pkg::CH_COMMA) begin
					phase_nx = PH_ELEM;
					res      = '{hit: 1'b1, kind: salp_pkg::K_END, ch: 8'h00};
				end else if (char_s1 == salp_pkg::CH_CLOSE) begin
					phase_nx = PH_CLOSED;
					res      = '{hit: 1'b1, kind: salp_pkg::K_END, ch: 8'h00};
				end else begin
					phase_nx = PH_UNQ;
					res      = '{hit: 1'b1, kind: salp_pkg::K_DATA, ch: char_s1};
				end
			end
			PH_UNQ: begin
				if (char_s1 == salp_pkg::CH_COMMA) begin
					phase_nx = PH_ELEM;
					res      = '{hit: 1'b1, kind: salp_pkg::K_END, ch: 8'h00};
				end else if (char_s1 == salp_pkg::CH_CLOSE) begin
					phase_nx = PH_CLOSED;
					res      = '{hit: 1'b1, kind: salp_pkg::K_END, ch: 8'h00};
				end else if (is_nul) begin
					phase_nx = PH_START;
					res      = '{hit: 1'b1, kind: salp_pkg::K_REJECT, ch: 8'h00};
				end else begin
					res      = '{hit: 1'b1, kind: salp_pkg::K_DATA, ch: char_s1};
				end
			end
			PH_QUOTE: begin
				if (is_nul) begin
					phase_nx = PH_START;
					res      = '{hit: 1'b1, kind: salp_pkg::K_REJECT, ch: 8'h00};
				end else if (char_s1 == salp_pkg::CH_BSL) begin
					phase_nx = PH_ESC;
				end else if (char_s1 == salp_pkg::CH_QUOTE) begin
					phase_nx = PH_AFTERQ;
				end else begin
					res      = '{hit: 1'b1, kind: salp_pkg::K_DATA, ch: char_s1};
				end
			end
			PH_ESC: begin
				if (is_nul) begin
					phase_nx = PH_START;
					res      = '{hit: 1'b1, kind: salp_pkg::K_REJECT, ch: 8'h00};
				end else begin
					phase_nx = PH_QUOTE;
					res      = '{hit: 1'b1, kind: salp_pkg::K_DATA, ch: char_s1};
				end
			end
			PH_AFTERQ: begin
				if (char_s1 == salp_pkg::CH_COMMA) begin
					phase_nx = PH_ELEM;
					res      = '{hit: 1'b1, kind: salp_pkg::K_END, ch: 8'h00};
				end else if (char_s1 == salp_pkg::CH_CLOSE) begin
					phase_nx = PH_CLOSED;
					res      = '{hit: 1'b1, kind: salp_pkg::K_END, ch: 8'h00};
				end else begin
					phase_nx = is_nul ? PH_START : PH_REJECTED;
					res      = '{hit: 1'b1, kind: salp_pkg::K_REJECT, ch: 8'h00};
				end
			end
			PH_CLOSED: begin
				if (is_nul) begin
					phase_nx = PH_START;
					res      = '{hit: 1'b1, kind: salp_pkg::K_ACCEPT, ch: 8'h00};
				end else begin
					phase_nx = PH_REJECTED;
					res      = '{hit: 1'b1, kind: salp_pkg::K_REJECT, ch: 8'h00};
				end
			end
			PH_REJECTED: begin
				// Everything up to the terminator is dropped silently.
				if (is_nul) begin
					phase_nx = PH_START;
				end
			end
			default: begin
				// Start phase; unused codes behave the same way.
				if (is_nul) begin
					phase_nx = PH_START;
					res      = '{hit: 1'b1, kind: salp_pkg::K_ACCEPT, ch: 8'h00};
				end else if (char_s1 == salp_pkg::CH_OPEN) begin
					phase_nx = PH_OPEN;
				end else begin
					phase_nx = PH_REJECTED;
					res      = '{hit: 1'b1, kind: salp_pkg::K_REJECT, ch: 8'h00};
				end
			end
		endcase
	end

	// Control state: stage valids, the parse phase and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			kind_s2  <= salp_pkg::K_DATA;
			char_s2  <= 8'h00;
			phase_q  <= PH_START;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (out_load) begin
				valid_s2 <= 1'b1;
				kind_s2  <= res.kind;
				char_s2  <= res.ch;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
			if (advance) begin
				phase_q <= phase_nx;
			end
		end
	end

	// Input byte register.
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = char_s2;
	assign m_tuser  = kind_s2;

	// A data byte is never the terminator, and other kinds carry a zero byte.
	a_data_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && res.kind == salp_pkg::K_DATA |-> res.ch != salp_pkg::CH_NUL)
		else $error("data result carries the terminator byte");

	a_mark_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != salp_pkg::K_DATA |-> m_tdata == 8'h00)
		else $error("non-data result carries a nonzero byte");

	// After an accept the parser is back at the start.
	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && res.kind == salp_pkg::K_ACCEPT |=> phase_q == PH_START)
		else $error("accept did not return to start");

	// A reject on the terminator restarts at once; any other reject drops input.
	a_reject_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && res.kind == salp_pkg::K_REJECT |=>
		(phase_q == PH_START) == ($past(char_s1) == salp_pkg::CH_NUL))
		else $error("reject left the parser in the wrong phase");

endmodule

`default_nettype wire
